### rtl/core/rm2q_pkg.sv
package rm2q_pkg;

  // Field format
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // Radicand: one plus three diagonal entries, signed
  localparam int RAD_W   = DATA_WIDTH + 2;
  // Square-root operand: positive radicand scaled by one, padded to even width
  localparam int SQ_RAW  = RAD_W - 1 + FRAC_BITS;
  localparam int SQ_W    = SQ_RAW + (SQ_RAW % 2);
  localparam int ROOT_W  = SQ_W / 2;
  localparam int SQR_W   = ROOT_W + 2;
  // Off-diagonal pair sums and differences
  localparam int D_W     = DATA_WIDTH + 1;
  localparam int MAG_W   = DATA_WIDTH + 1;
  // Long division: numerator (mag << FRAC_BITS) + root, divisor 2 * root
  localparam int NUM_W   = MAG_W + FRAC_BITS + 1;
  localparam int DIV_W   = ROOT_W + 1;
  localparam int DREM_W  = DIV_W + 1;

  localparam logic [NUM_W-1:0] SAT_POS = NUM_W'((64'(1) << (DATA_WIDTH - 1)) - 64'(1));
  localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(64'(1) << (DATA_WIDTH - 1));
  localparam logic [DATA_WIDTH-1:0] Q_MAX = DATA_WIDTH'(SAT_POS);
  localparam logic [DATA_WIDTH-1:0] Q_MIN = DATA_WIDTH'(SAT_NEG);
  localparam logic signed [RAD_W-1:0] ONE_R = RAD_W'(64'(1) << FRAC_BITS);

  // Branch that sets the radicand
  typedef enum logic [1:0] {
    SEL_TRACE,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  // Sideband that rides along the square-root stages
  typedef struct packed {
    sel_t                  sel;
    logic                  deg;
    logic signed [D_W-1:0] da;
    logic signed [D_W-1:0] db;
    logic signed [D_W-1:0] dc;
  } sq_side_t;

  // Sideband that rides along the divider stages
  typedef struct packed {
    sel_t              sel;
    logic              deg;
    logic [ROOT_W:0]   diag;
    logic [DIV_W-1:0]  dvs;
    logic              na;
    logic              nb;
    logic              nc;
  } dv_side_t;

  // Signed saturation of a magnitude with sign
  function automatic logic [DATA_WIDTH-1:0] sat_q(input logic neg,
                                                 input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0] negv;
    negv = ~mag + NUM_W'(1);
    if (!neg) begin
      sat_q = (mag > SAT_POS) ? Q_MAX : DATA_WIDTH'(mag);
    end else begin
      sat_q = (mag > SAT_NEG) ? Q_MIN : DATA_WIDTH'(negv);
    end
  endfunction

endpackage

### rtl/core/rotation_matrix_to_quaternion.sv
// Channel  | Direction | Handshake          | Beat payload
// in_      | input     | in_valid/in_stall  | in_m11 .. in_m33, signed Q2.14
// out_     | output    | out_valid/out_stall| out_quat_x/y/z/w Q2.14, out_degenerate
//
// One matrix per cycle while the output is not stalled.
// The pipeline depth is set by the bit-per-stage square root and the bit-per-stage dividers.
// Synchronous active-low reset clears all stage valid bits.
// A stall on a valid output freezes the whole pipeline; in_stall follows it, nothing
// is dropped or repeated. Bubbles travel as invalid stages.
module rotation_matrix_to_quaternion (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m11,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m12,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m13,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m21,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m22,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m23,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m31,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m32,
  input  logic signed [rm2q_pkg::DATA_WIDTH-1:0] in_m33,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [rm2q_pkg::DATA_WIDTH-1:0] out_quat_x,
  output logic signed [rm2q_pkg::DATA_WIDTH-1:0] out_quat_y,
  output logic signed [rm2q_pkg::DATA_WIDTH-1:0] out_quat_z,
  output logic signed [rm2q_pkg::DATA_WIDTH-1:0] out_quat_w,
  output logic                                   out_degenerate
);

  localparam int DW     = rm2q_pkg::DATA_WIDTH;
  localparam int FB     = rm2q_pkg::FRAC_BITS;
  localparam int RAD_W  = rm2q_pkg::RAD_W;
  localparam int SQ_W   = rm2q_pkg::SQ_W;
  localparam int ROOT_W = rm2q_pkg::ROOT_W;
  localparam int SQR_W  = rm2q_pkg::SQR_W;
  localparam int D_W    = rm2q_pkg::D_W;
  localparam int MAG_W  = rm2q_pkg::MAG_W;
  localparam int NUM_W  = rm2q_pkg::NUM_W;
  localparam int DREM_W = rm2q_pkg::DREM_W;

  localparam logic signed [RAD_W-1:0] ONE_R_C = rm2q_pkg::ONE_R;

  // Global advance: the pipeline moves unless a held result is stalled
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- Stage A: trace, compares, candidate radicands, pairs
  logic signed [RAD_W-1:0] e11, e22, e33, tr;
  logic signed [D_W-1:0]   e12, e13, e21, e23, e31, e32;

  assign e11 = RAD_W'(in_m11);
  assign e22 = RAD_W'(in_m22);
  assign e33 = RAD_W'(in_m33);
  assign e12 = D_W'(in_m12);
  assign e13 = D_W'(in_m13);
  assign e21 = D_W'(in_m21);
  assign e23 = D_W'(in_m23);
  assign e31 = D_W'(in_m31);
  assign e32 = D_W'(in_m32);
  assign tr  = e11 + e22 + e33;

  logic                    va_r;
  logic                    pos_r, ge12_r, ge13_r, gt23_r;
  logic signed [RAD_W-1:0] radt_r, radx_r, rady_r, radz_r;
  logic signed [D_W-1:0]   p23_r, p31_r, p12_r, s12_r, s13_r, s23_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
    if (adv) begin
      pos_r  <= (tr > 0);
      ge12_r <= (in_m11 >= in_m22);
      ge13_r <= (in_m11 >= in_m33);
      gt23_r <= (in_m22 > in_m33);
      radt_r <= ONE_R_C + tr;
      radx_r <= ONE_R_C + e11 - e22 - e33;
      rady_r <= ONE_R_C + e22 - e11 - e33;
      radz_r <= ONE_R_C + e33 - e11 - e22;
      p23_r  <= e23 - e32;
      p31_r  <= e31 - e13;
      p12_r  <= e12 - e21;
      s12_r  <= e12 + e21;
      s13_r  <= e13 + e31;
      s23_r  <= e32 + e23;
    end
  end

  // ---------------- Stage B: branch choice, radicand, pair routing
  rm2q_pkg::sel_t          sel_b;
  logic signed [RAD_W-1:0] rad_b;
  rm2q_pkg::sq_side_t      side_b;

  always_comb begin
    if (pos_r) begin
      sel_b = rm2q_pkg::SEL_TRACE;
    end else if (ge12_r && ge13_r) begin
      sel_b = rm2q_pkg::SEL_X;
    end else if (gt23_r) begin
      sel_b = rm2q_pkg::SEL_Y;
    end else begin
      sel_b = rm2q_pkg::SEL_Z;
    end
    side_b.sel = sel_b;
    unique case (sel_b)
      rm2q_pkg::SEL_TRACE: begin
        rad_b = radt_r; side_b.da = p23_r; side_b.db = p31_r; side_b.dc = p12_r;
      end
      rm2q_pkg::SEL_X: begin
        rad_b = radx_r; side_b.da = s12_r; side_b.db = s13_r; side_b.dc = p23_r;
      end
      rm2q_pkg::SEL_Y: begin
        rad_b = rady_r; side_b.da = s12_r; side_b.db = s23_r; side_b.dc = p31_r;
      end
      default: begin
        rad_b = radz_r; side_b.da = s13_r; side_b.db = s23_r; side_b.dc = p12_r;
      end
    endcase
    side_b.deg = (rad_b <= 0);
  end

  // ---------------- Square root: two radicand bits per stage
  logic               sq_v_r    [0:ROOT_W];
  logic [SQ_W-1:0]    sq_x_r    [0:ROOT_W];
  logic [SQR_W-1:0]   sq_rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]  sq_root_r [0:ROOT_W];
  rm2q_pkg::sq_side_t sq_side_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= va_r;
    end
    if (adv) begin
      sq_x_r[0]    <= SQ_W'({rad_b[RAD_W-2:0], {FB{1'b0}}});
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= side_b;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sq
    logic [SQR_W-1:0]  rem_sh, trial;
    logic [SQR_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    always_comb begin
      rem_sh = {sq_rem_r[i][SQR_W-3:0], sq_x_r[i][SQ_W-1 -: 2]};
      trial  = {sq_root_r[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {sq_root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {sq_root_r[i][ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[i+1] <= sq_v_r[i];
      end
      if (adv) begin
        sq_x_r[i+1]    <= {sq_x_r[i][SQ_W-3:0], 2'b00};
        sq_rem_r[i+1]  <= rem_nxt;
        sq_root_r[i+1] <= root_nxt;
        sq_side_r[i+1] <= sq_side_r[i];
      end
    end
  end

  // ---------------- Stage C: magnitudes, numerators, divisor, diagonal term
  logic [ROOT_W-1:0]  root_c;
  rm2q_pkg::sq_side_t sd_c;
  logic [MAG_W-1:0]   mag_a, mag_b, mag_c;
  rm2q_pkg::dv_side_t side_c;

  assign root_c = sq_root_r[ROOT_W];
  assign sd_c   = sq_side_r[ROOT_W];
  assign mag_a  = sd_c.da[D_W-1] ? MAG_W'(~sd_c.da + D_W'(1)) : MAG_W'(sd_c.da);
  assign mag_b  = sd_c.db[D_W-1] ? MAG_W'(~sd_c.db + D_W'(1)) : MAG_W'(sd_c.db);
  assign mag_c  = sd_c.dc[D_W-1] ? MAG_W'(~sd_c.dc + D_W'(1)) : MAG_W'(sd_c.dc);

  always_comb begin
    side_c.sel  = sd_c.sel;
    side_c.deg  = sd_c.deg;
    side_c.diag = ((ROOT_W + 1)'(root_c) + (ROOT_W + 1)'(1)) >> 1;
    side_c.dvs  = {root_c, 1'b0};
    side_c.na   = sd_c.da[D_W-1];
    side_c.nb   = sd_c.db[D_W-1];
    side_c.nc   = sd_c.dc[D_W-1];
  end

  // ---------------- Long division: one quotient bit per stage, three lanes
  logic               dv_v_r    [0:NUM_W];
  logic [NUM_W-1:0]   dv_n_r    [0:NUM_W][3];
  logic [DREM_W-1:0]  dv_rem_r  [0:NUM_W][3];
  logic [NUM_W-1:0]   dv_q_r    [0:NUM_W][3];
  rm2q_pkg::dv_side_t dv_side_r [0:NUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[ROOT_W];
    end
    if (adv) begin
      dv_n_r[0][0]   <= (NUM_W'(mag_a) << FB) + NUM_W'(root_c);
      dv_n_r[0][1]   <= (NUM_W'(mag_b) << FB) + NUM_W'(root_c);
      dv_n_r[0][2]   <= (NUM_W'(mag_c) << FB) + NUM_W'(root_c);
      dv_rem_r[0][0] <= '0;
      dv_rem_r[0][1] <= '0;
      dv_rem_r[0][2] <= '0;
      dv_q_r[0][0]   <= '0;
      dv_q_r[0][1]   <= '0;
      dv_q_r[0][2]   <= '0;
      dv_side_r[0]   <= side_c;
    end
  end

  for (genvar j = 0; j < NUM_W; j++) begin : g_dv
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [DREM_W-1:0] rem_sh, rem_nxt;
      logic              qbit;

      always_comb begin
        rem_sh = {dv_rem_r[j][k][DREM_W-2:0], dv_n_r[j][k][NUM_W-1]};
        qbit   = (rem_sh >= DREM_W'(dv_side_r[j].dvs));
        rem_nxt = qbit ? (rem_sh - DREM_W'(dv_side_r[j].dvs)) : rem_sh;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          dv_n_r[j+1][k]   <= {dv_n_r[j][k][NUM_W-2:0], 1'b0};
          dv_rem_r[j+1][k] <= rem_nxt;
          dv_q_r[j+1][k]   <= {dv_q_r[j][k][NUM_W-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
      if (adv) begin
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end
  end

  // ---------------- Output stage: sign, saturation, component placement
  rm2q_pkg::dv_side_t sd_o;
  logic [DW-1:0]      qa, qb, qc, qd;
  logic [DW-1:0]      x_nxt, y_nxt, z_nxt, w_nxt;

  assign sd_o = dv_side_r[NUM_W];
  assign qa   = rm2q_pkg::sat_q(sd_o.na, dv_q_r[NUM_W][0]);
  assign qb   = rm2q_pkg::sat_q(sd_o.nb, dv_q_r[NUM_W][1]);
  assign qc   = rm2q_pkg::sat_q(sd_o.nc, dv_q_r[NUM_W][2]);
  assign qd   = rm2q_pkg::sat_q(1'b0, NUM_W'(sd_o.diag));

  always_comb begin
    unique case (sd_o.sel)
      rm2q_pkg::SEL_TRACE: begin x_nxt = qa; y_nxt = qb; z_nxt = qc; w_nxt = qd; end
      rm2q_pkg::SEL_X:     begin x_nxt = qd; y_nxt = qa; z_nxt = qb; w_nxt = qc; end
      rm2q_pkg::SEL_Y:     begin x_nxt = qa; y_nxt = qd; z_nxt = qb; w_nxt = qc; end
      default:             begin x_nxt = qa; y_nxt = qb; z_nxt = qd; w_nxt = qc; end
    endcase
  end

  logic          out_valid_r, deg_r;
  logic [DW-1:0] qx_r, qy_r, qz_r, qw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[NUM_W];
    end
    if (adv) begin
      deg_r <= sd_o.deg;
      qx_r  <= sd_o.deg ? '0 : x_nxt;
      qy_r  <= sd_o.deg ? '0 : y_nxt;
      qz_r  <= sd_o.deg ? '0 : z_nxt;
      qw_r  <= sd_o.deg ? '0 : w_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degenerate = deg_r;
  assign out_quat_x     = qx_r;
  assign out_quat_y     = qy_r;
  assign out_quat_z     = qz_r;
  assign out_quat_w     = qw_r;

endmodule
